// ===== rtl/core/nli_pkg.sv =====
// shared types, constants and the microcode program of the interpolator
`timescale 1ns / 1ps

package nli_pkg;

    localparam int DEF_MAX_NODES   = 16;
    localparam int DEF_NUM_COLUMNS = 8;

    localparam int FUNC_W = 2;
    localparam int NODE_W = 4;
    localparam int COL_W  = 3;
    localparam int DUR_W  = 16;
    localparam int SMP_W  = 32;
    localparam int TIME_W = 20;
    localparam int NN_W   = 5;
    localparam int TAU_W  = 16;
    localparam int TCNT_W = $clog2(TAU_W);
    localparam int SUM_W  = DUR_W + NODE_W + 1;
    localparam int DIFF_W = SMP_W + 1;
    localparam int PROD_W = TAU_W + 1 + DIFF_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    localparam int PC_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_WR_DUR = 2'd0,
        FN_WR_SMP = 2'd1,
        FN_QUERY  = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        OP_IDLE   = 4'd0,
        OP_WALK   = 4'd1,
        OP_SETUP  = 4'd2,
        OP_LDPREV = 4'd3,
        OP_LDCUR  = 4'd4,
        OP_DIV    = 4'd5,
        OP_SUB    = 4'd6,
        OP_MUL    = 4'd7,
        OP_FIN    = 4'd8,
        OP_MISS   = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        JC_NONE    = 3'd0,
        JC_QUERY   = 3'd1,
        JC_STOP    = 3'd2,
        JC_MISS    = 3'd3,
        JC_DIVDONE = 3'd4,
        JC_OUTFREE = 3'd5
    } cond_t;

    localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] PC_WALK   = 4'd1;
    localparam logic [PC_W-1:0] PC_SETUP  = 4'd2;
    localparam logic [PC_W-1:0] PC_LDPREV = 4'd3;
    localparam logic [PC_W-1:0] PC_LDCUR  = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV    = 4'd5;
    localparam logic [PC_W-1:0] PC_SUB    = 4'd6;
    localparam logic [PC_W-1:0] PC_MUL    = 4'd7;
    localparam logic [PC_W-1:0] PC_FIN    = 4'd8;
    localparam logic [PC_W-1:0] PC_MISS   = 4'd9;

    // cond true: go to target; else hold stays on the step, or falls through
    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic            hold;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic query_start;
        logic stop;
        logic miss;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [SMP_W-1:0]  value;
        logic              valid;
        logic [NODE_W-1:0] seg;
    } result_t;

    typedef struct packed {
        func_t              func;
        logic [NODE_W-1:0]  node_index;
        logic [COL_W-1:0]   column;
        logic [DUR_W-1:0]   duration;
        logic [SMP_W-1:0]   sample_value;
        logic [TIME_W-1:0]  query_time;
    } in_item_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            PC_IDLE:   w = '{OP_IDLE,   JC_QUERY,   1'b1, PC_WALK};
            PC_WALK:   w = '{OP_WALK,   JC_STOP,    1'b1, PC_SETUP};
            PC_SETUP:  w = '{OP_SETUP,  JC_MISS,    1'b0, PC_MISS};
            PC_LDPREV: w = '{OP_LDPREV, JC_NONE,    1'b0, PC_IDLE};
            PC_LDCUR:  w = '{OP_LDCUR,  JC_NONE,    1'b0, PC_IDLE};
            PC_DIV:    w = '{OP_DIV,    JC_DIVDONE, 1'b1, PC_SUB};
            PC_SUB:    w = '{OP_SUB,    JC_NONE,    1'b0, PC_IDLE};
            PC_MUL:    w = '{OP_MUL,    JC_NONE,    1'b0, PC_IDLE};
            PC_FIN:    w = '{OP_FIN,    JC_OUTFREE, 1'b1, PC_IDLE};
            PC_MISS:   w = '{OP_MISS,   JC_OUTFREE, 1'b1, PC_IDLE};
            default:   w = '{OP_IDLE,   JC_NONE,    1'b0, PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/nonuniform_linear_interpolator_core.sv =====
// top level of the nonuniform piecewise linear interpolator
`timescale 1ns / 1ps

// Piecewise linear interpolator over nodes of unequal length. Duration and
// sample writes give no result beat. A query walks the node durations one
// node a cycle, then runs a 16-step restoring divider for the Q0.16
// fraction and a multiply-add over the two neighbouring samples, read one
// after the other through the single read port of the sample ram. The
// segment walk loop and the divider account for most of a query's run time;
// a miss ends after the walk, without the divider or the multiply-add.
// Only one query is in flight; the finished result sits in an output
// register, and a new beat is taken while it waits. Both tables read as
// zero after reset; no clearing pass is needed.
module nonuniform_linear_interpolator_core #(
    parameter int MAX_NODES   = nli_pkg::DEF_MAX_NODES,
    parameter int NUM_COLUMNS = nli_pkg::DEF_NUM_COLUMNS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nli_pkg::NN_W-1:0]            cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // node_index, column, duration, sample_value, query_time, zero pad
    input  logic [nli_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func
    input  logic [nli_pkg::FUNC_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // interp_value, segment_index, zero pad
    output logic [nli_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // time_valid
    output logic [0:0]                          m_axis_tuser
);
    import nli_pkg::*;

    localparam int ENODES = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);

    ucode_t     word;
    dp_status_t status;
    result_t    result;
    in_item_t   item;
    logic       out_free;
    logic       load_out;

    logic [NN_W-1:0]   num_nodes_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [SMP_W-1:0]  m_value_reg;
    logic [NODE_W-1:0] m_seg_reg;
    logic              m_tv_reg;

    assign item.func         = func_t'(s_axis_tuser);
    assign item.node_index   = s_axis_tdata[3:0];
    assign item.column       = s_axis_tdata[6:4];
    assign item.duration     = s_axis_tdata[22:7];
    assign item.sample_value = s_axis_tdata[54:23];
    assign item.query_time   = s_axis_tdata[74:55];

    assign s_axis_tready = (word.op == OP_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign load_out      = ((word.op == OP_FIN) || (word.op == OP_MISS)) && out_free;
    assign m_valid_next  = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    nli_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .out_free (out_free),
        .word     (word)
    );

    nli_datapath #(
        .MAX_NODES   (MAX_NODES),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .in_valid  (s_axis_tvalid),
        .item      (item),
        .num_nodes (num_nodes_reg),
        .status    (status),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_nodes_reg <= NN_W'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_nodes_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_value_reg <= result.value;
            m_seg_reg   <= result.seg;
            m_tv_reg    <= result.valid;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SMP_W - NODE_W){1'b0}}, m_seg_reg, m_value_reg};
    assign m_axis_tuser  = m_tv_reg;

`ifndef SYNTHESIS
    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_valid_reg || m_axis_tready))
    else $error("result loaded over a pending beat");

    // a query beat puts the sequencer to work
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FN_QUERY)) |=> !s_axis_tready)
    else $error("query accepted but sequencer stayed idle");

    // a miss beat carries zero value and zero segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("miss result with non-zero payload");

    // a hit always names a node that has storage
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> ((NN_W)'(m_axis_tdata[35:32]) < NN_W'(ENODES)))
    else $error("segment index beyond the node table");
`endif

endmodule

// ===== rtl/core/nli_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module nli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/nli_seq.sv =====
// microcode sequencer: step counter, program rom and jump logic
`timescale 1ns / 1ps

module nli_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  nli_pkg::dp_status_t status,
    input  logic                out_free,
    output nli_pkg::ucode_t     word
);
    import nli_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_true;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        case (word.cond)
            JC_NONE:    cond_true = 1'b0;
            JC_QUERY:   cond_true = status.query_start;
            JC_STOP:    cond_true = status.stop;
            JC_MISS:    cond_true = status.miss;
            JC_DIVDONE: cond_true = status.div_done;
            JC_OUTFREE: cond_true = out_free;
            default:    cond_true = 1'b0;
        endcase

        if (cond_true)
        begin
            pc_next = word.target;
        end
        else if (word.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/nli_datapath.sv =====
// datapath: duration table, sample ram, segment walk, divider and multiply-add
`timescale 1ns / 1ps

module nli_datapath #(
    parameter int MAX_NODES   = nli_pkg::DEF_MAX_NODES,
    parameter int NUM_COLUMNS = nli_pkg::DEF_NUM_COLUMNS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nli_pkg::ucode_t             word,
    input  logic                        in_valid,
    input  nli_pkg::in_item_t           item,
    input  logic [nli_pkg::NN_W-1:0]    num_nodes,
    output nli_pkg::dp_status_t         status,
    output nli_pkg::result_t            result
);
    import nli_pkg::*;

    // only nodes and columns reachable by the write fields get storage
    localparam int ENODES   = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int ECOLS    = (NUM_COLUMNS < (1 << COL_W)) ? NUM_COLUMNS : (1 << COL_W);
    localparam int ESAMPLES = ENODES * ECOLS;
    localparam int IDX_W    = (ENODES > 1) ? $clog2(ENODES) : 1;
    localparam int SADDR_W  = (ESAMPLES > 1) ? $clog2(ESAMPLES) : 1;

    logic [DUR_W-1:0]   dur_reg [ENODES];
    logic [ESAMPLES-1:0] vld_reg;

    logic [TIME_W-1:0]  t_reg;
    logic [COL_W-1:0]   col_reg;
    logic [NN_W-1:0]    i_reg;
    logic [SUM_W-1:0]   start_reg;
    logic               found_reg;
    logic [NODE_W-1:0]  seg_reg;
    logic [DUR_W-1:0]   div_reg;
    logic [DUR_W-1:0]   rem_reg;
    logic [TAU_W-1:0]   tau_reg;
    logic [TCNT_W-1:0]  cnt_reg;
    logic               prev_ok_reg;
    logic               cur_ok_reg;
    logic signed [SMP_W-1:0]  s_prev_reg;
    logic signed [SMP_W-1:0]  s_cur_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic               accept;
    logic               wr_node_ok;
    logic               wr_col_ok;
    logic               q_col_ok;
    logic [NN_W-1:0]    n_eff;
    logic               walk_end;
    logic               hit;
    logic [DUR_W-1:0]   d_cur;
    logic [SUM_W-1:0]   seg_end;
    logic [NODE_W-1:0]  prev_node;
    logic [SADDR_W-1:0] waddr;
    logic [SADDR_W-1:0] prev_addr;
    logic [SADDR_W-1:0] cur_addr;
    logic [SADDR_W-1:0] raddr;
    logic [SMP_W-1:0]   rdata;
    logic               smp_we;
    logic [DUR_W:0]     rem_shift;
    logic               q_bit;
    logic signed [ACC_W-1:0] acc;

    assign accept     = in_valid && (word.op == OP_IDLE);
    assign wr_node_ok = (NN_W'(item.node_index) < NN_W'(ENODES));
    assign wr_col_ok  = ((COL_W + 1)'(item.column) < (COL_W + 1)'(ECOLS));
    assign q_col_ok   = ((COL_W + 1)'(col_reg) < (COL_W + 1)'(ECOLS));
    assign smp_we     = accept && (item.func == FN_WR_SMP) && wr_node_ok && wr_col_ok;

    assign n_eff    = (num_nodes > NN_W'(ENODES)) ? NN_W'(ENODES) : num_nodes;
    assign walk_end = (i_reg >= n_eff);
    assign d_cur    = walk_end ? '0 : dur_reg[i_reg[IDX_W-1:0]];
    assign seg_end  = start_reg + SUM_W'(d_cur);
    // zero-length segments fail the upper bound by themselves
    assign hit      = !walk_end && (SUM_W'(t_reg) >= start_reg) && (SUM_W'(t_reg) < seg_end);

    assign prev_node = (seg_reg == '0) ? '0 : seg_reg - 1'b1;

    assign waddr     = SADDR_W'(item.node_index) * SADDR_W'(ECOLS)
                     + SADDR_W'(wr_col_ok ? item.column : '0);
    assign prev_addr = SADDR_W'(prev_node) * SADDR_W'(ECOLS)
                     + SADDR_W'(q_col_ok ? col_reg : '0);
    assign cur_addr  = SADDR_W'(seg_reg) * SADDR_W'(ECOLS)
                     + SADDR_W'(q_col_ok ? col_reg : '0);
    assign raddr     = (word.op == OP_SETUP) ? prev_addr : cur_addr;

    nli_ram #(
        .WIDTH (SMP_W),
        .DEPTH (ESAMPLES)
    ) u_samples (
        .clk   (clk),
        .we    (smp_we),
        .waddr (waddr),
        .wdata (item.sample_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // one restoring division step
    assign rem_shift = {rem_reg, 1'b0};
    assign q_bit     = (rem_shift >= {1'b0, div_reg});

    // prev * 2^16 + tau * (cur - prev), then floor by the arithmetic shift
    assign acc = {{(ACC_W - SMP_W - TAU_W){s_prev_reg[SMP_W-1]}}, s_prev_reg, {TAU_W{1'b0}}}
               + {prod_reg[PROD_W-1], prod_reg};

    assign status.query_start = accept && (item.func == FN_QUERY);
    assign status.stop        = hit || walk_end;
    assign status.miss        = !found_reg;
    assign status.div_done    = (cnt_reg == TCNT_W'(TAU_W - 1));

    always_comb
    begin
        if (word.op == OP_FIN)
        begin
            result.value = acc[TAU_W +: SMP_W];
            result.valid = 1'b1;
            result.seg   = seg_reg;
        end
        else
        begin
            result.value = '0;
            result.valid = 1'b0;
            result.seg   = '0;
        end
    end

    // duration table and sample valid bits cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENODES; k++)
            begin
                dur_reg[k] <= '0;
            end
            vld_reg <= '0;
        end
        else
        begin
            if (accept && (item.func == FN_WR_DUR) && wr_node_ok)
            begin
                dur_reg[item.node_index[IDX_W-1:0]] <= item.duration;
            end
            if (smp_we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            i_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (word.op)
                OP_IDLE:
                begin
                    if (status.query_start)
                    begin
                        found_reg <= 1'b0;
                        i_reg     <= '0;
                    end
                end
                OP_WALK:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    else if (!walk_end)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                OP_SETUP: cnt_reg <= '0;
                OP_DIV:   cnt_reg <= cnt_reg + 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (word.op)
            OP_IDLE:
            begin
                if (status.query_start)
                begin
                    t_reg     <= item.query_time;
                    col_reg   <= item.column;
                    start_reg <= '0;
                end
            end
            OP_WALK:
            begin
                if (hit)
                begin
                    seg_reg <= i_reg[NODE_W-1:0];
                    div_reg <= d_cur;
                end
                else if (!walk_end)
                begin
                    start_reg <= seg_end;
                end
            end
            OP_SETUP:
            begin
                rem_reg     <= DUR_W'(SUM_W'(t_reg) - start_reg);
                tau_reg     <= '0;
                prev_ok_reg <= (seg_reg != '0) && q_col_ok && vld_reg[prev_addr];
            end
            OP_LDPREV:
            begin
                s_prev_reg <= prev_ok_reg ? $signed(rdata) : '0;
                cur_ok_reg <= q_col_ok && vld_reg[cur_addr];
            end
            OP_LDCUR:
            begin
                s_cur_reg <= cur_ok_reg ? $signed(rdata) : '0;
            end
            OP_DIV:
            begin
                rem_reg <= q_bit ? DUR_W'(rem_shift - {1'b0, div_reg}) : rem_shift[DUR_W-1:0];
                tau_reg <= {tau_reg[TAU_W-2:0], q_bit};
            end
            OP_SUB:
            begin
                diff_reg <= {s_cur_reg[SMP_W-1], s_cur_reg} - {s_prev_reg[SMP_W-1], s_prev_reg};
            end
            OP_MUL:
            begin
                prod_reg <= $signed({1'b0, tau_reg}) * diff_reg;
            end
            default: ;
        endcase
    end

endmodule

// ===== verif/nonuniform_linear_interpolator_core_tb.sv =====
// self-checking testbench for the nonuniform piecewise linear interpolator core
`timescale 1ns / 1ps

module nonuniform_linear_interpolator_core_tb;

    import nli_pkg::*;

    localparam int          MAX_N        = DEF_MAX_NODES;
    localparam int          N_COL        = DEF_NUM_COLUMNS;
    localparam int          RANDOM_ITEMS = 1650;
    localparam int          SETTLE       = 48;
    localparam int          LONG_HOLD    = 300;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // shadow copy of the node tables, predicting every query result
    class interp_shadow;
        logic [DUR_W-1:0] seg_len [MAX_N];
        logic [SMP_W-1:0] node_val [MAX_N*N_COL];
        logic [NN_W-1:0]  node_count;
        result_t          pending_interps [$];
        int               mismatches;

        function new();
            foreach (seg_len[i]) seg_len[i] = '0;
            foreach (node_val[i]) node_val[i] = '0;
            node_count = NN_W'(1);
            mismatches = 0;
        endfunction

        function void set_node_count(input logic [NN_W-1:0] v);
            node_count = v;
        endfunction

        function int active_nodes();
            return (node_count > MAX_N) ? MAX_N : int'(node_count);
        endfunction

        function longint span();
            longint total;
            total = 0;
            for (int i = 0; i < active_nodes(); i++)
                total += seg_len[i];
            return total;
        endfunction

        function int pending();
            return pending_interps.size();
        endfunction

        function void note_beat(input in_item_t it);
            result_t r;
            longint  start;
            longint  d;
            longint  tau;
            longint  prev_s;
            longint  cur_s;
            longint  acc;
            bit      found;
            case (it.func)
                FN_WR_DUR: seg_len[it.node_index] = it.duration;
                FN_WR_SMP: node_val[{it.node_index, it.column}] = it.sample_value;
                FN_QUERY:
                begin
                    r = '0;
                    start = 0;
                    found = 1'b0;
                    for (int i = 0; i < active_nodes() && !found; i++)
                    begin
                        d = seg_len[i];
                        if (it.query_time >= start && it.query_time < start + d)
                        begin
                            found = 1'b1;
                            r.valid = 1'b1;
                            r.seg = NODE_W'(i);
                        end
                        else
                            start += d;
                    end
                    if (found)
                    begin
                        tau = ((longint'(it.query_time) - start) << 16) / seg_len[r.seg];
                        cur_s = $signed(node_val[{r.seg, it.column}]);
                        if (r.seg == 0)
                            acc = tau * cur_s;
                        else
                        begin
                            prev_s = $signed(node_val[{r.seg - NODE_W'(1), it.column}]);
                            acc = (65536 - tau) * prev_s + tau * cur_s;
                        end
                        // arithmetic shift gives the floor
                        r.value = SMP_W'(acc >>> 16);
                    end
                    pending_interps.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_interp(input logic [SMP_W-1:0] value, input logic valid,
                                   input logic [NODE_W-1:0] seg);
            result_t got;
            result_t want;
            got = '{value: value, valid: valid, seg: seg};
            if (pending_interps.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: value=%h valid=%b seg=%0d",
                             value, valid, seg);
                mismatches++;
                return;
            end
            want = pending_interps.pop_front();
            if (got.value !== want.value || got.valid !== want.valid || got.seg !== want.seg)
            begin
                if (mismatches < 10)
                    $display({"mismatch: expected value=%h valid=%b seg=%0d, ",
                              "got value=%h valid=%b seg=%0d"},
                             want.value, want.valid, want.seg,
                             got.value, got.valid, got.seg);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [NN_W-1:0]        cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    interp_shadow sb = new();
    bit           hold_req = 1'b0;
    bit           hold_done = 1'b0;
    bit           steady = 1'b0;
    int           burst_left = 0;
    int           items_sent = 0;
    int unsigned  cycle_cnt = 0;

    nonuniform_linear_interpolator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic in_item_t make_item(input func_t f, input int node, input int col,
                                           input int dur, input logic [SMP_W-1:0] smp,
                                           input int t);
        in_item_t it;
        it.func = f;
        it.node_index = NODE_W'(node);
        it.column = COL_W'(col);
        it.duration = DUR_W'(dur);
        it.sample_value = smp;
        it.query_time = TIME_W'(t);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.func = func_t'($urandom_range(0, 3));
        it.node_index = NODE_W'($urandom_range(0, MAX_N - 1));
        it.column = COL_W'($urandom_range(0, N_COL - 1));
        it.duration = DUR_W'($urandom_range(0, 65535));
        it.sample_value = $urandom();
        it.query_time = TIME_W'($urandom_range(0, (1 << TIME_W) - 1));
        return it;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration(input int style);
        case (style)
            0: return DUR_W'($urandom_range(0, 40));
            1: return DUR_W'($urandom_range(0, 65535));
            2: return ($urandom_range(0, 3) == 0) ? DUR_W'($urandom_range(1, 500)) : '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic pause_sender(input int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
                pause_sender(gap);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, it.query_time, it.sample_value, it.duration,
                          it.column, it.node_index};
        s_axis_tuser  <= it.func;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_beat(it);
        if (it.func != FN_NONE)
            items_sent++;
    endtask

    // sender stops until every result is back, then lets the core settle
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_node_count(input int v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= NN_W'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_node_count(NN_W'(v));
    endtask

    task automatic run_directed();
        // empty tables after reset: every query misses
        send_item(make_item(FN_QUERY, 0, 0, 0, '0, 0));
        send_item(make_item(FN_NONE, 5, 3, 123, 32'h1234_5678, 77));
        send_item(make_item(FN_WR_DUR, 0, 0, 65535, '0, 0));
        send_item(make_item(FN_WR_SMP, 0, 7, 0, 32'h7FFF_FFFF, 0));
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 0));
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 65534));
        // end of the segment is exclusive
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 65535));
        send_item(make_item(FN_WR_SMP, 0, 0, 0, 32'h8000_0000, 0));
        send_item(make_item(FN_QUERY, 0, 0, 0, '0, 32768));
        send_item(make_item(FN_WR_DUR, 1, 0, 1, '0, 0));
        send_item(make_item(FN_WR_SMP, 1, 7, 0, 32'h8000_0000, 0));
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 65535));
        write_node_count(MAX_N);
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 65535));
        send_item(make_item(FN_WR_DUR, 15, 0, 65535, '0, 0));
        // zero-length nodes in between are skipped
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 65536));
        send_item(make_item(FN_WR_SMP, 15, 7, 0, 32'hFFFF_FFFF, 0));
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 131070));
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 20'hFFFFF));
        write_node_count(0);
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 0));
        // count above the table size saturates
        write_node_count(31);
        send_item(make_item(FN_QUERY, 0, 7, 0, '0, 65535));
    endtask

    task automatic run_phase(input int phase);
        int       nodes_list [6] = '{16, 1, 0, 31, 17, 8};
        int       style;
        int       roll;
        longint   limit;
        in_item_t it;
        write_node_count((phase < 6) ? nodes_list[phase] : $urandom_range(0, 31));
        steady = (phase % 4 == 2) || (phase == 3);
        if (phase == 3)
            hold_req = 1'b1;
        style = $urandom_range(0, 3);
        for (int i = 0; i < MAX_N; i++)
        begin
            it = random_item();
            it.func = FN_WR_DUR;
            it.node_index = NODE_W'(i);
            it.duration = pick_duration(style);
            send_item(it);
        end
        repeat (16)
        begin
            it = random_item();
            it.func = FN_WR_SMP;
            it.sample_value = pick_sample();
            send_item(it);
        end
        repeat (110)
        begin
            it = random_item();
            roll = $urandom_range(0, 99);
            if (roll < 62)
            begin
                it.func = FN_QUERY;
                limit = sb.span();
                if (limit > (1 << TIME_W) - 1)
                    limit = (1 << TIME_W) - 1;
                if ($urandom_range(0, 9) != 0)
                    it.query_time = TIME_W'($urandom_range(0, int'(limit)));
            end
            else if (roll < 84)
            begin
                it.func = FN_WR_SMP;
                it.sample_value = pick_sample();
            end
            else if (roll < 92)
            begin
                it.func = FN_WR_DUR;
                it.duration = pick_duration(style);
            end
            else if (roll < 96)
                it.func = FN_NONE;
            send_item(it);
        end
    endtask

    // receiver: changing ready pattern, with one long hold on request
    initial
    begin : rx_ready
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                tick++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (tick % 4 != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_interp(m_axis_tdata[SMP_W-1:0], m_axis_tuser[0],
                            m_axis_tdata[SMP_W+NODE_W-1:SMP_W]);

    initial
    begin
        int phase;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            run_phase(phase);
            phase++;
        end
        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/nli_pkg.sv
rtl/core/nli_ram.sv
rtl/core/nli_seq.sv
rtl/core/nli_datapath.sv
rtl/core/nonuniform_linear_interpolator_core.sv
verif/nonuniform_linear_interpolator_core_tb.sv
